### rtl/compacting_copy_with_index_map_assert.svh
// Assertion macros for the compacting copy block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef COMPACTING_COPY_WITH_INDEX_MAP_ASSERT_SVH
`define COMPACTING_COPY_WITH_INDEX_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCIM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccim assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CCIM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccim assertion failed");

`endif

### rtl/ccim_pkg.sv
// Shared constants, codes and types of the compacting copy block.
// Used by ccim_ifs, ccim_out_fifo and the top level; depends on nothing.
`default_nettype none

package ccim_pkg;

	// Capacity and payload size.
	localparam int MAX_ELEMS = 1024;
	localparam int ELEM_BITS = 32;

	// Field widths of the channels.
	localparam int MODE_W = 2;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int STAT_W = 2;

	// Organization of the deletion bitmap memory: rows of bits.
	localparam int ROW_BITS = 32;
	localparam int ROWS = MAX_ELEMS / ROW_BITS;
	localparam int BIT_AW = $clog2(ROW_BITS);
	localparam int ROW_AW = $clog2(ROWS);

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MARK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PASS = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_MARK_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_ALL_DELETED = 2'd2;
	localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

	// One result item as it travels from the compute stage to the output queue.
	typedef struct packed {
		logic kept;
		logic [IDX_W-1:0] new_index;
		logic [IDX_W-1:0] source_index;
		logic [ELEM_BITS-1:0] elem_out;
		logic [CNT_W-1:0] kept_count;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

`default_nettype wire

### rtl/ccim_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on ccim_pkg for the field widths.
`default_nettype none

interface ccim_in_if;
	logic valid;
	logic ready;
	logic [ccim_pkg::MODE_W-1:0] mode;
	logic [ccim_pkg::IDX_W-1:0] mark_index;
	logic [ccim_pkg::ELEM_BITS-1:0] elem_in;
	logic last_elem;

	modport source(output valid, mode, mark_index, elem_in, last_elem, input ready);
	modport sink(input valid, mode, mark_index, elem_in, last_elem, output ready);
endinterface

interface ccim_out_if;
	logic valid;
	logic ready;
	logic kept;
	logic [ccim_pkg::IDX_W-1:0] new_index;
	logic [ccim_pkg::IDX_W-1:0] source_index;
	logic [ccim_pkg::ELEM_BITS-1:0] elem_out;
	logic [ccim_pkg::CNT_W-1:0] kept_count;
	logic [ccim_pkg::STAT_W-1:0] status;

	modport source(output valid, kept, new_index, source_index, elem_out, kept_count,
		status, input ready);
	modport sink(input valid, kept, new_index, source_index, elem_out, kept_count,
		status, output ready);
endinterface

`default_nettype wire

### rtl/ccim_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package needed.
`default_nettype none

module ccim_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first in program order; a read of the same address returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/ccim_out_fifo.sv
// Two-entry result queue that drives the result channel.
// Depends on ccim_pkg (result_t) and ccim_ifs (ccim_out_if).
`default_nettype none

module ccim_out_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ccim_pkg::result_t push_data,
	output logic [1:0] count,
	ccim_out_if.source results
);

	ccim_pkg::result_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign pop = results.valid && results.ready;
	assign count = count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Head of the queue onto the channel.
	always_comb begin
		results.valid = (count_q != 2'd0);
		results.kept = entry_q[rd_ptr_q].kept;
		results.new_index = entry_q[rd_ptr_q].new_index;
		results.source_index = entry_q[rd_ptr_q].source_index;
		results.elem_out = entry_q[rd_ptr_q].elem_out;
		results.kept_count = entry_q[rd_ptr_q].kept_count;
		results.status = entry_q[rd_ptr_q].status;
	end

endmodule

`default_nettype wire

### rtl/compacting_copy_with_index_map.sv
// Top level of the compacting copy block; depends on ccim_pkg, ccim_ifs, ccim_ram,
// ccim_out_fifo and the assertion macro header.
//
// Usage: items arrive on the items channel (valid/ready). A clear item starts a job,
// mark items set a bit of the deletion bitmap, and pass items walk the source elements
// in order. Every item gives exactly one result on the results channel, in order.
// A result is offered once its item has passed the s1 stage (the bitmap read) and then
// the output queue. Mark and pass items sustain one transfer per cycle while the
// receiver keeps up; the bitmap row is read in the accept cycle and written back in the
// cycle after, with the freshly written row forwarded to a following item on the same row.
// A clear item holds off further items during its compute cycle and then while the
// sweep zeroes the bitmap, one 32-bit row per cycle.
// After reset the same sweep runs before the first item is taken.
// When the receiver stalls, the compute stage and the output queue together hold at
// most two results; ready drops once two are in flight and returns as the queue drains.
`default_nettype none
`include "compacting_copy_with_index_map_assert.svh"

module compacting_copy_with_index_map (
	input wire logic clk,
	input wire logic arst_n,
	ccim_in_if.sink items,
	ccim_out_if.source results
);

	// Stage s1 registers: the item whose bitmap row is being read.
	logic valid_s1;
	logic [ccim_pkg::MODE_W-1:0] mode_s1;
	logic [ccim_pkg::ROW_AW-1:0] row_s1;
	logic [ccim_pkg::BIT_AW-1:0] bit_s1;
	logic [ccim_pkg::ELEM_BITS-1:0] elem_s1;
	logic last_s1;
	logic [ccim_pkg::CNT_W-1:0] sidx_s1;
	logic range_err_s1;

	// Job counters, bitmap sweep and forwarding registers.
	logic [ccim_pkg::CNT_W-1:0] src_q;
	logic [ccim_pkg::CNT_W-1:0] kept_q;
	logic sweep_q;
	logic [ccim_pkg::ROW_AW-1:0] sweep_row_q;
	logic fwd_valid_q;
	logic [ccim_pkg::ROW_AW-1:0] fwd_row_q;
	logic [ccim_pkg::ROW_BITS-1:0] fwd_data_q;

	logic accept;
	logic src_full;
	logic [ccim_pkg::IDX_W-1:0] rd_index;
	logic [ccim_pkg::ROW_AW-1:0] rd_row;
	logic [ccim_pkg::ROW_BITS-1:0] ram_rdata;
	logic [ccim_pkg::ROW_BITS-1:0] row_data;
	logic [ccim_pkg::ROW_BITS-1:0] row_new;
	logic mark_write;
	logic clear_s1;
	logic ram_we;
	logic [ccim_pkg::ROW_AW-1:0] ram_waddr;
	logic [ccim_pkg::ROW_BITS-1:0] ram_wdata;
	logic [ccim_pkg::CNT_W-1:0] kept_next;
	ccim_pkg::result_t res;
	logic [1:0] fifo_count;
	logic pop;
	logic [2:0] level_next;

	// Input handshake: hold off during a clear in s1, during the sweep and while room could run out.
	assign pop = results.valid && results.ready;
	assign level_next = {1'b0, fifo_count} + {2'b00, valid_s1} - {2'b00, pop};
	assign clear_s1 = valid_s1 && (mode_s1 == ccim_pkg::MODE_CLEAR);
	assign items.ready = !sweep_q && !clear_s1 && (level_next <= 3'd1);
	assign accept = items.valid && items.ready;

	// Bitmap read address: the marked index or the current source position.
	assign src_full = (src_q == ccim_pkg::CNT_W'(ccim_pkg::MAX_ELEMS));
	assign rd_index = (items.mode == ccim_pkg::MODE_MARK) ? items.mark_index
		: src_q[ccim_pkg::IDX_W-1:0];
	assign rd_row = rd_index[ccim_pkg::BIT_AW +: ccim_pkg::ROW_AW];

	// Stage s1 capture and the source counter, which needs no bitmap data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			src_q <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (items.mode == ccim_pkg::MODE_CLEAR) begin
					src_q <= '0;
				end else if (items.mode == ccim_pkg::MODE_PASS && !src_full) begin
					src_q <= src_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= items.mode;
			row_s1 <= rd_row;
			bit_s1 <= rd_index[ccim_pkg::BIT_AW-1:0];
			elem_s1 <= items.elem_in;
			last_s1 <= items.last_elem;
			sidx_s1 <= src_q;
			range_err_s1 <= ({7'd0, items.mark_index} >= 17'(ccim_pkg::MAX_ELEMS));
		end
	end

	// Row data, with the row written in the previous cycle forwarded.
	assign row_data = (fwd_valid_q && (fwd_row_q == row_s1)) ? fwd_data_q : ram_rdata;
	assign row_new = row_data | (ccim_pkg::ROW_BITS'(1) << bit_s1);
	assign mark_write = valid_s1 && (mode_s1 == ccim_pkg::MODE_MARK) && !range_err_s1;

	// Result of the item in s1.
	always_comb begin
		res = '0;
		kept_next = kept_q;
		unique case (mode_s1)
			ccim_pkg::MODE_CLEAR: begin
				kept_next = '0;
			end
			ccim_pkg::MODE_MARK: begin
				res.kept_count = kept_q;
				res.status = range_err_s1 ? ccim_pkg::ST_MARK_RANGE : ccim_pkg::ST_OK;
			end
			ccim_pkg::MODE_PASS: begin
				res.source_index = sidx_s1[ccim_pkg::IDX_W-1:0];
				if (sidx_s1 == ccim_pkg::CNT_W'(ccim_pkg::MAX_ELEMS)) begin
					res.status = ccim_pkg::ST_TOO_MANY;
				end else begin
					if (!row_data[bit_s1]) begin
						res.kept = 1'b1;
						res.new_index = kept_q[ccim_pkg::IDX_W-1:0];
						res.elem_out = elem_s1;
						kept_next = kept_q + 1'b1;
					end
					if (last_s1 && kept_next == '0) begin
						res.status = ccim_pkg::ST_ALL_DELETED;
					end
				end
				res.kept_count = kept_next;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Kept counter, sweep sequencer and forwarding registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			sweep_q <= 1'b1;
			sweep_row_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (valid_s1) begin
				kept_q <= kept_next;
			end
			if (clear_s1) begin
				sweep_q <= 1'b1;
				sweep_row_q <= '0;
			end else if (sweep_q) begin
				if (sweep_row_q == ccim_pkg::ROW_AW'(ccim_pkg::ROWS - 1)) begin
					sweep_q <= 1'b0;
					sweep_row_q <= '0;
				end else begin
					sweep_row_q <= sweep_row_q + 1'b1;
				end
			end
			fwd_valid_q <= mark_write;
		end
	end

	always_ff @(posedge clk) begin
		if (mark_write) begin
			fwd_row_q <= row_s1;
			fwd_data_q <= row_new;
		end
	end

	// Bitmap write port: sweep zeroes rows, marks write back the modified row.
	assign ram_we = sweep_q || mark_write;
	assign ram_waddr = sweep_q ? sweep_row_q : row_s1;
	assign ram_wdata = sweep_q ? '0 : row_new;

	ccim_ram #(
		.WIDTH(ccim_pkg::ROW_BITS),
		.DEPTH(ccim_pkg::ROWS)
	) u_bitmap (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_row),
		.rdata(ram_rdata)
	);

	ccim_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s1),
		.push_data(res),
		.count(fifo_count),
		.results(results)
	);

	// No item is taken while the bitmap is being swept.
	`CCIM_ASSERT_SAME(a_no_accept_in_sweep, sweep_q, !items.ready)
	// A mark write-back never collides with the sweep on the write port.
	`CCIM_ASSERT_SAME(a_no_mark_in_sweep, mark_write, !sweep_q)
	// The output queue never overflows.
	`CCIM_ASSERT_SAME(a_fifo_room, valid_s1 && !pop, fifo_count != 2'd2)
	// Outside a clear in flight, no more elements are kept than were passed.
	`CCIM_ASSERT_SAME(a_kept_bound, !clear_s1, kept_q <= src_q)

endmodule

`default_nettype wire
